// File: rtl/euler_zyx_to_quaternion_core_assert.svh
// Assertion macros for the Euler-to-quaternion core.
// Used by the top level; needs no other file.
`ifndef EULER_ZYX_TO_QUATERNION_CORE_ASSERT_SVH
`define EULER_ZYX_TO_QUATERNION_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define EZQ_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ezq implication failed");
`define EZQ_ASSERT_NEVER(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("ezq forbidden condition seen");
`else
`define EZQ_ASSERT_IMPLY(name, ante, cons)
`define EZQ_ASSERT_NEVER(name, cond)
`endif
`endif

// File: rtl/ezq_pkg.sv
// Shared constants, types and the arctangent table function for the core.
// Depends on nothing.
`default_nettype none
package ezq_pkg;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int OUT_FRAC_BITS = 15;
    localparam int TRIG_ITERATIONS = 16;
    localparam int ANGLE_W = 16;
    localparam int OUT_W = 16;
    localparam int ACC_W = 34;
    localparam int TRIG_W = 32;
    localparam int PROD_W = 64;
    localparam int SUM_W = 65;
    localparam int LANE_LATENCY = TRIG_ITERATIONS + 1;
    localparam int MERGE_LATENCY = 3;
    localparam int TOTAL_LATENCY = LANE_LATENCY + MERGE_LATENCY;
    localparam int ANGLE_SHIFT = 29 - ANGLE_FRAC_BITS;
    localparam int OUT_SHIFT = 60 - OUT_FRAC_BITS;

    localparam logic signed [ACC_W-1:0] Q30_ONE = 34'sd1073741824;
    localparam logic signed [ACC_W-1:0] Q30_PI = 34'sd3373259426;
    localparam logic signed [ACC_W-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [ACC_W-1:0] Q30_GAIN = 34'sd652032874;
    localparam longint Q30_ATAN_ONE = 64'sd843314857;
    localparam logic signed [SUM_W-1:0] OUT_MAX = 65'sd32767;
    localparam logic signed [SUM_W-1:0] OUT_MIN = -65'sd32768;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } trig_t;

    // Shift-and-subtract quotient of two non-negative values, used only at elaboration.
    function automatic longint quotient_u63(input longint num, input longint den);
        longint quo;
        longint rem;
        quo = 0;
        rem = 0;
        for (int b = 62; b >= 0; b--)
        begin
            rem = (rem <<< 1) | ((num >>> b) & longint'(1));
            quo = quo <<< 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | longint'(1);
            end
        end
        return quo;
    endfunction

    function automatic longint atan_q30(input int i);
        longint sum;
        longint term;
        longint den;
        int e;
        sum = 0;
        if (i == 0) begin
            return Q30_ATAN_ONE;
        end
        for (int k = 0; k < 32; k++) begin
            e = i * (2 * k + 1);
            if (e <= 62) begin
                den = longint'(2 * k + 1);
                term = quotient_u63(longint'(1) <<< (62 - e), den);
                sum = ((k & 1) == 1) ? sum - term : sum + term;
            end
        end
        return (sum + (longint'(1) <<< 31)) >>> 32;
    endfunction
endpackage
`default_nettype wire

// File: rtl/euler_zyx_to_quaternion_core.sv
// Converts ZYX Euler angles in Q3.13 radians to a Q1.15 unit quaternion. A beat is
// taken on any cycle start is high; busy is never raised, so one beat per cycle is
// sustained. Each result appears on the quat ports for one cycle with done high,
// after the fold register, the folded 16-stage CORDIC lanes and the merge's trig
// product, final product and output registers. The receiver cannot stall the block.
`default_nettype none
`include "euler_zyx_to_quaternion_core_assert.svh"
module euler_zyx_to_quaternion_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [ezq_pkg::ANGLE_W-1:0]  roll_angle,
    input  wire logic signed [ezq_pkg::ANGLE_W-1:0]  pitch_angle,
    input  wire logic signed [ezq_pkg::ANGLE_W-1:0]  yaw_angle,
    output logic                                     done,
    output logic signed [ezq_pkg::OUT_W-1:0]         quat_w,
    output logic signed [ezq_pkg::OUT_W-1:0]         quat_x,
    output logic signed [ezq_pkg::OUT_W-1:0]         quat_y,
    output logic signed [ezq_pkg::OUT_W-1:0]         quat_z
);
    localparam int L = ezq_pkg::TOTAL_LATENCY;

    ezq_pkg::trig_t roll_t, pitch_t, yaw_t;
    logic [L-1:0] valid_reg;
    logic [L-1:0] valid_next;

    ezq_cordic_lane u_roll  (.clk(clk), .angle(roll_angle),  .trig(roll_t));
    ezq_cordic_lane u_pitch (.clk(clk), .angle(pitch_angle), .trig(pitch_t));
    ezq_cordic_lane u_yaw   (.clk(clk), .angle(yaw_angle),   .trig(yaw_t));

    ezq_merge u_merge (
        .clk(clk), .roll_t(roll_t), .pitch_t(pitch_t), .yaw_t(yaw_t),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z)
    );

    assign valid_next = {valid_reg[L-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign busy = 1'b0;
    assign done = valid_reg[L-1];

    `EZQ_ASSERT_NEVER(a_never_busy, busy)
    `EZQ_ASSERT_IMPLY(a_start_done, start, ##20 done)
    `EZQ_ASSERT_IMPLY(a_done_origin, done, $past(start, 20))
endmodule
`default_nettype wire

// File: rtl/ezq_cordic_lane.sv
// One sine/cosine lane: half-angle fold followed by a pipelined CORDIC.
// Depends on ezq_pkg.
`default_nettype none
module ezq_cordic_lane (
    input  wire logic                                 clk,
    input  wire logic signed [ezq_pkg::ANGLE_W-1:0]   angle,
    output ezq_pkg::trig_t                            trig
);
    localparam int N = ezq_pkg::TRIG_ITERATIONS;
    localparam int W = ezq_pkg::ACC_W;

    logic signed [W-1:0] x_reg [0:N];
    logic signed [W-1:0] y_reg [0:N];
    logic signed [W-1:0] r_reg [0:N];
    logic                neg_reg [0:N];
    logic signed [W-1:0] r_in;
    logic signed [W-1:0] r_next;
    logic                neg_next;
    logic signed [W-1:0] x_clamp;
    logic signed [W-1:0] y_clamp;

    always_comb
    begin
        r_in = W'(angle) <<< ezq_pkg::ANGLE_SHIFT;
        r_next = r_in;
        neg_next = 1'b0;
        if (r_in > ezq_pkg::Q30_HALF_PI)
        begin
            r_next = ezq_pkg::Q30_PI - r_in;
            neg_next = 1'b1;
        end
        else if (r_in < -ezq_pkg::Q30_HALF_PI)
        begin
            r_next = -ezq_pkg::Q30_PI - r_in;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= ezq_pkg::Q30_GAIN;
        y_reg[0] <= '0;
        r_reg[0] <= r_next;
        neg_reg[0] <= neg_next;
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        localparam logic signed [W-1:0] ATAN_I = W'(ezq_pkg::atan_q30(i));
        always_ff @(posedge clk)
        begin
            if (r_reg[i][W-1])
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                r_reg[i+1] <= r_reg[i] + ATAN_I;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                r_reg[i+1] <= r_reg[i] - ATAN_I;
            end
            neg_reg[i+1] <= neg_reg[i];
        end
    end

    always_comb
    begin
        if (x_reg[N] > ezq_pkg::Q30_ONE)
            x_clamp = ezq_pkg::Q30_ONE;
        else if (x_reg[N] < -ezq_pkg::Q30_ONE)
            x_clamp = -ezq_pkg::Q30_ONE;
        else
            x_clamp = x_reg[N];
        if (y_reg[N] > ezq_pkg::Q30_ONE)
            y_clamp = ezq_pkg::Q30_ONE;
        else if (y_reg[N] < -ezq_pkg::Q30_ONE)
            y_clamp = -ezq_pkg::Q30_ONE;
        else
            y_clamp = y_reg[N];
        trig.cos_v = neg_reg[N] ? ezq_pkg::TRIG_W'(-x_clamp) : ezq_pkg::TRIG_W'(x_clamp);
        trig.sin_v = ezq_pkg::TRIG_W'(y_clamp);
    end
endmodule
`default_nettype wire

// File: rtl/ezq_merge.sv
// Merging stage: combines the three lanes into the quaternion by the ZYX products.
// Depends on ezq_pkg.
`default_nettype none
module ezq_merge (
    input  wire logic                                clk,
    input  wire ezq_pkg::trig_t                      roll_t,
    input  wire ezq_pkg::trig_t                      pitch_t,
    input  wire ezq_pkg::trig_t                      yaw_t,
    output logic signed [ezq_pkg::OUT_W-1:0]         quat_w,
    output logic signed [ezq_pkg::OUT_W-1:0]         quat_x,
    output logic signed [ezq_pkg::OUT_W-1:0]         quat_y,
    output logic signed [ezq_pkg::OUT_W-1:0]         quat_z
);
    localparam int TW = ezq_pkg::TRIG_W;
    localparam int PW = ezq_pkg::PROD_W;
    localparam int SW = ezq_pkg::SUM_W;
    localparam logic signed [PW-1:0] HALF30 = PW'(64'sd1) <<< 29;
    localparam logic signed [SW-1:0] HALF_OUT = SW'(65'sd1) <<< (ezq_pkg::OUT_SHIFT - 1);

    logic signed [TW-1:0] crcp_reg, srsp_reg, srcp_reg, crsp_reg, cy_reg, sy_reg;
    logic signed [PW-1:0] p_reg [0:7];
    logic signed [SW-1:0] s_next [0:3];
    logic signed [SW-1:0] r_next [0:3];
    logic signed [ezq_pkg::OUT_W-1:0] q_next [0:3];

    function automatic logic signed [TW-1:0] mul_q30(input logic signed [TW-1:0] a,
                                                     input logic signed [TW-1:0] b);
        logic signed [PW-1:0] p;
        p = (PW'(a) * PW'(b) + HALF30) >>> 30;
        return p[TW-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        crcp_reg <= mul_q30(roll_t.cos_v, pitch_t.cos_v);
        srsp_reg <= mul_q30(roll_t.sin_v, pitch_t.sin_v);
        srcp_reg <= mul_q30(roll_t.sin_v, pitch_t.cos_v);
        crsp_reg <= mul_q30(roll_t.cos_v, pitch_t.sin_v);
        cy_reg <= yaw_t.cos_v;
        sy_reg <= yaw_t.sin_v;
        p_reg[0] <= PW'(crcp_reg) * PW'(cy_reg);
        p_reg[1] <= PW'(srsp_reg) * PW'(sy_reg);
        p_reg[2] <= PW'(srcp_reg) * PW'(cy_reg);
        p_reg[3] <= PW'(crsp_reg) * PW'(sy_reg);
        p_reg[4] <= PW'(crsp_reg) * PW'(cy_reg);
        p_reg[5] <= PW'(srcp_reg) * PW'(sy_reg);
        p_reg[6] <= PW'(crcp_reg) * PW'(sy_reg);
        p_reg[7] <= PW'(srsp_reg) * PW'(cy_reg);
    end

    always_comb
    begin
        s_next[0] = SW'(p_reg[0]) + SW'(p_reg[1]);
        s_next[1] = SW'(p_reg[2]) - SW'(p_reg[3]);
        s_next[2] = SW'(p_reg[4]) + SW'(p_reg[5]);
        s_next[3] = SW'(p_reg[6]) - SW'(p_reg[7]);
        for (int k = 0; k < 4; k++)
        begin
            r_next[k] = (s_next[k] + HALF_OUT) >>> ezq_pkg::OUT_SHIFT;
            if (r_next[k] > ezq_pkg::OUT_MAX)
                q_next[k] = ezq_pkg::OUT_W'(ezq_pkg::OUT_MAX);
            else if (r_next[k] < ezq_pkg::OUT_MIN)
                q_next[k] = ezq_pkg::OUT_W'(ezq_pkg::OUT_MIN);
            else
                q_next[k] = r_next[k][ezq_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        quat_w <= q_next[0];
        quat_x <= q_next[1];
        quat_y <= q_next[2];
        quat_z <= q_next[3];
    end
endmodule
`default_nettype wire

// File: tb/euler_zyx_to_quaternion_core_test.sv
// Self-checking testbench for the ZYX Euler angle to quaternion core.
// Predicts each quaternion with its own CORDIC and product arithmetic; needs ezq_pkg and the core.
`timescale 1ns / 1ps
module euler_zyx_to_quaternion_core_test;
    typedef struct {
        logic signed [ezq_pkg::ANGLE_W-1:0] roll;
        logic signed [ezq_pkg::ANGLE_W-1:0] pitch;
        logic signed [ezq_pkg::ANGLE_W-1:0] yaw;
    } angles_t;

    typedef struct {
        logic signed [ezq_pkg::OUT_W-1:0] w;
        logic signed [ezq_pkg::OUT_W-1:0] x;
        logic signed [ezq_pkg::OUT_W-1:0] y;
        logic signed [ezq_pkg::OUT_W-1:0] z;
    } quat_t;

    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint PI_Q30 = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TWO_PI_Q30 = 64'sd6746518852;
    localparam longint GAIN_Q30 = 64'sd652032874;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [ezq_pkg::ANGLE_W-1:0] roll_angle;
    logic signed [ezq_pkg::ANGLE_W-1:0] pitch_angle;
    logic signed [ezq_pkg::ANGLE_W-1:0] yaw_angle;
    logic done;
    logic signed [ezq_pkg::OUT_W-1:0] quat_w;
    logic signed [ezq_pkg::OUT_W-1:0] quat_x;
    logic signed [ezq_pkg::OUT_W-1:0] quat_y;
    logic signed [ezq_pkg::OUT_W-1:0] quat_z;

    angles_t pending_angles[$];
    quat_t expected_quats[$];
    longint arctan_table[32];
    int errors;
    int idle_cycles;
    int gap_left;
    bit stimulus_done;
    bit hold_for_drain;

    euler_zyx_to_quaternion_core i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .roll_angle(roll_angle),
        .pitch_angle(pitch_angle),
        .yaw_angle(yaw_angle),
        .done(done),
        .quat_w(quat_w),
        .quat_x(quat_x),
        .quat_y(quat_y),
        .quat_z(quat_z)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_half_up(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint arctan_pow2(int i);
        longint acc;
        longint term;
        int e;
        acc = 0;
        if (i == 0)
        begin
            return 64'sd843314857;
        end
        for (int k = 0; k < 32; k++)
        begin
            e = i * (2 * k + 1);
            if (e > 62)
            begin
                break;
            end
            term = (longint'(1) <<< (62 - e)) / longint'(2 * k + 1);
            acc = (k % 2 == 1) ? acc - term : acc + term;
        end
        return round_half_up(acc, 32);
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v > ONE_Q30)
        begin
            return ONE_Q30;
        end
        if (v < -ONE_Q30)
        begin
            return -ONE_Q30;
        end
        return v;
    endfunction

    task automatic half_angle_trig(input logic signed [ezq_pkg::ANGLE_W-1:0] angle,
                                   output longint cos_v, output longint sin_v);
        longint r;
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        bit flip;
        flip = 1'b0;
        r = longint'(angle) * (longint'(1) <<< (29 - ezq_pkg::ANGLE_FRAC_BITS));
        r = r % TWO_PI_Q30;
        if (r >= PI_Q30)
        begin
            r -= TWO_PI_Q30;
        end
        else if (r < -PI_Q30)
        begin
            r += TWO_PI_Q30;
        end
        if (r > HALF_PI_Q30)
        begin
            r = PI_Q30 - r;
            flip = 1'b1;
        end
        else if (r < -HALF_PI_Q30)
        begin
            r = -PI_Q30 - r;
            flip = 1'b1;
        end
        cx = GAIN_Q30;
        cy = 0;
        for (int i = 0; i < ezq_pkg::TRIG_ITERATIONS && i < 32; i++)
        begin
            dx = floor_shift(cy, i);
            dy = floor_shift(cx, i);
            if (r >= 0)
            begin
                cx -= dx;
                cy += dy;
                r -= arctan_table[i];
            end
            else
            begin
                cx += dx;
                cy -= dy;
                r += arctan_table[i];
            end
        end
        cx = clamp_unit(cx);
        cy = clamp_unit(cy);
        cos_v = flip ? -cx : cx;
        sin_v = cy;
    endtask

    function automatic longint mul_q30(longint a, longint b);
        return round_half_up(a * b, 30);
    endfunction

    function automatic logic signed [ezq_pkg::OUT_W-1:0] to_q15(longint v60);
        longint v;
        v = round_half_up(v60, 60 - ezq_pkg::OUT_FRAC_BITS);
        if (v > 32767)
        begin
            v = 32767;
        end
        if (v < -32768)
        begin
            v = -32768;
        end
        return v[ezq_pkg::OUT_W-1:0];
    endfunction

    task automatic predict_quaternion(input angles_t a, output quat_t q);
        longint cr;
        longint sr;
        longint cp;
        longint sp;
        longint cyw;
        longint syw;
        half_angle_trig(a.roll, cr, sr);
        half_angle_trig(a.pitch, cp, sp);
        half_angle_trig(a.yaw, cyw, syw);
        q.w = to_q15(mul_q30(cr, cp) * cyw + mul_q30(sr, sp) * syw);
        q.x = to_q15(mul_q30(sr, cp) * cyw - mul_q30(cr, sp) * syw);
        q.y = to_q15(mul_q30(cr, sp) * cyw + mul_q30(sr, cp) * syw);
        q.z = to_q15(mul_q30(cr, cp) * syw - mul_q30(sr, sp) * cyw);
    endtask

    function automatic logic signed [ezq_pkg::ANGLE_W-1:0] random_angle();
        case ($urandom_range(0, 9))
            0: return ezq_pkg::ANGLE_W'($urandom);
            1: return ezq_pkg::ANGLE_W'($urandom_range(0, 8) * 6434 - 25736
                                        + $urandom_range(0, 4) - 2);
            default: return ezq_pkg::ANGLE_W'(int'($urandom_range(0, 51472)) - 25736);
        endcase
    endfunction

    task automatic queue_angles(input logic signed [ezq_pkg::ANGLE_W-1:0] r,
                                input logic signed [ezq_pkg::ANGLE_W-1:0] p,
                                input logic signed [ezq_pkg::ANGLE_W-1:0] y);
        angles_t a;
        a.roll = r;
        a.pitch = p;
        a.yaw = y;
        pending_angles = {pending_angles, a};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        angles_t a;
        quat_t q;
        if (!rst_n)
        begin
            start <= 1'b0;
            roll_angle <= '0;
            pitch_angle <= '0;
            yaw_angle <= '0;
            gap_left = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                a.roll = roll_angle;
                a.pitch = pitch_angle;
                a.yaw = yaw_angle;
                predict_quaternion(a, q);
                expected_quats = {expected_quats, q};
            end
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (hold_for_drain || pending_angles.size() == 0)
                begin
                    start <= 1'b0;
                end
                else
                begin
                    a = pending_angles.pop_front();
                    start <= 1'b1;
                    roll_angle <= a.roll;
                    pitch_angle <= a.pitch;
                    yaw_angle <= a.yaw;
                    case ($urandom_range(0, 19))
                        0: gap_left = $urandom_range(10, 40);
                        1, 2, 3, 4, 5: gap_left = $urandom_range(1, 3);
                        default: gap_left = 0;
                    endcase
                end
            end
        end
    end

    always @(posedge clk)
    begin
        quat_t q;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_quats.size() == 0)
                begin
                    $display("%0t: unexpected beat w=%0d x=%0d y=%0d z=%0d",
                             $time, quat_w, quat_x, quat_y, quat_z);
                    errors++;
                end
                else
                begin
                    q = expected_quats.pop_front();
                    if (quat_w !== q.w)
                    begin
                        $display("%0t: quat_w expected %0d actual %0d", $time, q.w, quat_w);
                        errors++;
                    end
                    if (quat_x !== q.x)
                    begin
                        $display("%0t: quat_x expected %0d actual %0d", $time, q.x, quat_x);
                        errors++;
                    end
                    if (quat_y !== q.y)
                    begin
                        $display("%0t: quat_y expected %0d actual %0d", $time, q.y, quat_y);
                        errors++;
                    end
                    if (quat_z !== q.z)
                    begin
                        $display("%0t: quat_z expected %0d actual %0d", $time, q.z, quat_z);
                        errors++;
                    end
                end
            end
            if ((start && !busy) || done)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[euler_zyx_to_quaternion_core] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        logic signed [ezq_pkg::ANGLE_W-1:0] edges[8];
        errors = 0;
        idle_cycles = 0;
        stimulus_done = 1'b0;
        hold_for_drain = 1'b0;
        for (int i = 0; i < 32; i++)
        begin
            arctan_table[i] = arctan_pow2(i);
        end
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        edges = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868, -16'sd12868,
                  16'sd32767, -16'sd32768, 16'sd1};
        for (int i = 0; i < 8; i++)
        begin
            queue_angles(edges[i], edges[(i + 3) % 8], edges[(i + 5) % 8]);
        end
        queue_angles(16'sd0, 16'sd0, 16'sd0);
        queue_angles(16'sd25736, 16'sd0, 16'sd0);
        queue_angles(16'sd0, 16'sd25736, 16'sd0);
        queue_angles(16'sd0, 16'sd0, 16'sd25736);
        queue_angles(16'sd25736, 16'sd25736, 16'sd25736);
        queue_angles(-16'sd25736, -16'sd25736, -16'sd25736);
        queue_angles(16'sd32767, -16'sd32768, 16'sd32767);
        queue_angles(-16'sd1, 16'sd12869, -16'sd12869);
        queue_angles(16'sh5555, 16'shAAAA, 16'sh0F0F);
        queue_angles(16'shAAAA, 16'sh5555, 16'shF0F0);
        while (pending_angles.size() > 0 || start) @(posedge clk);

        hold_for_drain = 1'b1;
        while (expected_quats.size() > 0) @(posedge clk);
        hold_for_drain = 1'b0;

        for (int n = 0; n < 1330; n++)
        begin
            queue_angles(random_angle(), random_angle(), random_angle());
        end
        while (pending_angles.size() > 0 || start) @(posedge clk);
        while (expected_quats.size() > 0) @(posedge clk);
        repeat (ezq_pkg::TOTAL_LATENCY + 10) @(posedge clk);

        if (errors == 0)
        begin
            $display("[euler_zyx_to_quaternion_core] OK");
        end
        else
        begin
            $display("[euler_zyx_to_quaternion_core] ERROR");
        end
        $finish;
    end
endmodule
